// ===== hdl/srbs_pkg.sv =====
// Shared types and constants for the sorted range bounds search block.
`timescale 1ns / 1ps

package srbs_pkg;

  localparam int DEPTH_DEFAULT       = 1024;
  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int INPUT_WIDTH         = 32;
  localparam int IDX_W               = 11;
  localparam int QUEUE_DEPTH         = 2;
  localparam int QUEUE_AW            = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW            = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    KIND_APPEND,
    KIND_CLEAR,
    KIND_QUERY
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADDR,
    ST_STEP,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/srbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module srbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/srbs_front.sv =====
// Front end: takes input transfers, decodes the opcode and queues work items.
`timescale 1ns / 1ps

module srbs_front #(
  parameter int VALUE_WIDTH = srbs_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [63:0]            s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,
  output logic                   q_valid,
  output srbs_pkg::kind_t        q_kind,
  output logic [VALUE_WIDTH-1:0] q_value,
  input  logic                   q_pop
);

  srbs_pkg::kind_t              kinds  [srbs_pkg::QUEUE_DEPTH];
  logic [VALUE_WIDTH-1:0]       values [srbs_pkg::QUEUE_DEPTH];
  logic [srbs_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [srbs_pkg::QUEUE_CW-1:0] fill;

  logic                   accept, push, pop;
  srbs_pkg::kind_t        in_kind;
  logic [31:0]            raw;
  logic [63:0]            ext;
  logic [VALUE_WIDTH-1:0] ordered;

  assign s_axis_tready = (fill != srbs_pkg::QUEUE_CW'(srbs_pkg::QUEUE_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_kind = srbs_pkg::KIND_QUERY;
    push    = 1'b0;
    raw     = s_axis_tdata[63:32];
    unique case (s_axis_tuser)
      srbs_pkg::OP_APPEND: begin
        in_kind = srbs_pkg::KIND_APPEND;
        push    = accept;
        raw     = s_axis_tdata[31:0];
      end
      srbs_pkg::OP_CLEAR: begin
        in_kind = srbs_pkg::KIND_CLEAR;
        push    = accept;
      end
      srbs_pkg::OP_QUERY: begin
        in_kind = srbs_pkg::KIND_QUERY;
        push    = accept;
      end
      default: begin
        push = 1'b0;  // unused opcode: taken and dropped
      end
    endcase
  end

  // sign-extend, resize, then flip the sign bit so unsigned order is signed order
  assign ext     = {{(64 - srbs_pkg::INPUT_WIDTH){raw[31]}}, raw};
  assign ordered = ext[VALUE_WIDTH-1:0] ^ {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

  assign q_valid = (fill != '0);
  assign q_kind  = kinds[rd_ptr];
  assign q_value = values[rd_ptr];
  assign pop     = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      kinds[wr_ptr]  <= in_kind;
      values[wr_ptr] <= ordered;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == srbs_pkg::QUEUE_AW'(srbs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == srbs_pkg::QUEUE_AW'(srbs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/srbs_engine.sv =====
// Back end: applies appends and clears, runs both binary searches, holds the result.
`timescale 1ns / 1ps

module srbs_engine #(
  parameter int DEPTH       = srbs_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = srbs_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  srbs_pkg::kind_t        q_kind,
  input  logic [VALUE_WIDTH-1:0] q_value,
  output logic                   q_pop,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [23:0]            m_axis_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  srbs_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [VALUE_WIDTH-1:0] key, key_next;
  logic [CW-1:0] lo, lo_next, hix, hix_next, mid, mid_next;
  logic [CW-1:0] hit_l, hit_l_next, hit_r, hit_r_next;
  logic found_l, found_l_next, found_r, found_r_next;
  logic right, right_next;
  logic out_valid, out_valid_next;
  logic signed [srbs_pkg::IDX_W-1:0] out_first, out_first_next;
  logic signed [srbs_pkg::IDX_W-1:0] out_last, out_last_next;
  logic out_found, out_found_next;

  logic                   we;
  logic [AW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] rdata;
  logic [CW:0]            sum_cur, sum_new;
  logic [CW-1:0]          mid_cur, mid_new, nlo, nhix;

  srbs_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(count[AW-1:0]),
    .wdata(q_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  // midpoint of the window [lo, hix), only used when lo < hix
  assign sum_cur = {1'b0, lo} + {1'b0, hix} - (CW + 1)'(1);
  assign mid_cur = sum_cur[CW:1];

  // one compare step on the word read at mid
  always_comb begin
    nlo  = lo;
    nhix = hix;
    if (rdata > key) begin
      nhix = mid;
    end else if (rdata < key) begin
      nlo = mid + 1'b1;
    end else if (right) begin
      nlo = mid + 1'b1;
    end else begin
      nhix = mid;
    end
  end

  assign sum_new = {1'b0, nlo} + {1'b0, nhix} - (CW + 1)'(1);
  assign mid_new = sum_new[CW:1];
  assign raddr   = (state == srbs_pkg::ST_STEP) ? mid_new[AW-1:0] : mid_cur[AW-1:0];

  always_comb begin
    state_next     = state;
    count_next     = count;
    key_next       = key;
    lo_next        = lo;
    hix_next       = hix;
    mid_next       = mid;
    hit_l_next     = hit_l;
    hit_r_next     = hit_r;
    found_l_next   = found_l;
    found_r_next   = found_r;
    right_next     = right;
    out_valid_next = out_valid && !m_axis_tready;
    out_first_next = out_first;
    out_last_next  = out_last;
    out_found_next = out_found;
    q_pop          = 1'b0;
    we             = 1'b0;

    unique case (state)
      srbs_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_kind)
            srbs_pkg::KIND_APPEND: begin
              if (count < CW'(DEPTH)) begin
                we         = 1'b1;
                count_next = count + 1'b1;
              end
            end
            srbs_pkg::KIND_CLEAR: begin
              count_next = '0;
            end
            srbs_pkg::KIND_QUERY: begin
              key_next     = q_value;
              lo_next      = '0;
              hix_next     = count;
              right_next   = 1'b0;
              found_l_next = 1'b0;
              found_r_next = 1'b0;
              state_next   = srbs_pkg::ST_ADDR;
            end
            default: begin
              state_next = srbs_pkg::ST_IDLE;
            end
          endcase
        end
      end
      srbs_pkg::ST_ADDR: begin
        if (lo < hix) begin
          mid_next   = mid_cur;
          state_next = srbs_pkg::ST_STEP;
        end else if (!right) begin
          right_next = 1'b1;
          lo_next    = '0;
          hix_next   = count;
        end else begin
          state_next = srbs_pkg::ST_DONE;
        end
      end
      srbs_pkg::ST_STEP: begin
        lo_next  = nlo;
        hix_next = nhix;
        if (rdata == key) begin
          if (right) begin
            hit_r_next   = mid;
            found_r_next = 1'b1;
          end else begin
            hit_l_next   = mid;
            found_l_next = 1'b1;
          end
        end
        if (nlo < nhix) begin
          mid_next = mid_new;
        end else if (!right) begin
          right_next = 1'b1;
          lo_next    = '0;
          hix_next   = count;
          state_next = srbs_pkg::ST_ADDR;
        end else begin
          state_next = srbs_pkg::ST_DONE;
        end
      end
      srbs_pkg::ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_first_next = found_l ? signed'(srbs_pkg::IDX_W'(hit_l)) : '1;
          out_last_next  = found_r ? signed'(srbs_pkg::IDX_W'(hit_r)) : '1;
          out_found_next = found_l || found_r;
          state_next     = srbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srbs_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      right     <= 1'b0;
      found_l   <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      right     <= right_next;
      found_l   <= found_l_next;
      found_r   <= found_r_next;
    end
  end

  always_ff @(posedge clk) begin
    key       <= key_next;
    lo        <= lo_next;
    hix       <= hix_next;
    mid       <= mid_next;
    hit_l     <= hit_l_next;
    hit_r     <= hit_r_next;
    out_first <= out_first_next;
    out_last  <= out_last_next;
    out_found <= out_found_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_found, out_last, out_first};

endmodule

// ===== hdl/sorted_range_bounds_search.sv =====
// Top level of the sorted range bounds search block.
//
// Usage: a stream of items enters on s_axis. tuser carries the opcode: append
// (element_value in tdata[31:0] is written at the next free index), clear
// (store emptied), query (search_key in tdata[63:32]). Opcode 3 is taken and
// ignored. Appends to a full store are dropped. Contents are expected sorted
// in non-decreasing signed order.
// Each query yields one transfer on m_axis: first and last index of the key,
// both -1 when absent, and a found flag. Appends and clears yield nothing.
// Items pass through a two-entry queue into the execution engine. An append or
// clear is applied by the engine in its idle state. In a query, each search step
// is one read of the single store read port, and the result is loaded in the
// done state after the second search ends, once the output register is free.
// Reset (rst, synchronous) empties the store and the queue and drops any
// pending result. A stalled result waits in the output register; appends and
// clears behind it still run; the next query's result waits in the done state.
`timescale 1ns / 1ps

module sorted_range_bounds_search #(
  parameter int DEPTH       = srbs_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = srbs_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // element_value[31:0], search_key[63:32]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // first_index[10:0], last_index[21:11], found[22]
);

  logic                   q_valid;
  logic                   q_pop;
  srbs_pkg::kind_t        q_kind;
  logic [VALUE_WIDTH-1:0] q_value;

  srbs_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .q_valid      (q_valid),
    .q_kind       (q_kind),
    .q_value      (q_value),
    .q_pop        (q_pop)
  );

  srbs_engine #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_kind       (q_kind),
    .q_value      (q_value),
    .q_pop        (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule
